### rtl/core/lrf_pkg.sv
// Package for the lidar repulsive force field block: widths, register indexes,
// the configuration and item-kind structs, and the exp and arctangent tables.
// Used by every module of the block; depends on nothing.
package lrf_pkg;

   localparam int COORD_WIDTH_DEFAULT = 16;
   localparam int ACC_WIDTH_DEFAULT   = 40;
   localparam int CORNER_COUNT        = 4;
   localparam int CORNER_W            = $clog2(CORNER_COUNT);
   localparam int QUEUE_DEPTH         = 4;

   localparam int WIDTH_W   = 14;
   localparam int GAIN_W    = 16;
   localparam int RANGE_W   = 14;
   localparam int CSR_ADDR_W = 2;
   localparam int CSR_DATA_W = 16;

   localparam int TQ_W         = 18;
   localparam int EXP_STEPS    = 16;
   localparam int E_W          = 31;
   localparam int F_W          = 24;
   localparam int Q_W          = 17;
   localparam int MAG_W        = 32;
   localparam int ANG_W        = 16;
   localparam int RSP_TDATA_W  = 48;
   localparam int SQRT_RAD_W   = 64;
   localparam int SQRT_ROOT_W  = 32;
   localparam int CORDIC_STEPS = 24;
   localparam int CORDIC_W     = 33;

   localparam logic [E_W-1:0] ONE_Q30 = 31'd1073741824;

   typedef enum logic [CSR_ADDR_W-1:0] {
      CSR_WIDTH  = 2'd0,
      CSR_LENGTH = 2'd1,
      CSR_GAIN   = 2'd2,
      CSR_RANGE  = 2'd3
   } csr_index_type;

   localparam logic [WIDTH_W-1:0] WIDTH_RESET  = 14'd500;
   localparam logic [WIDTH_W-1:0] LENGTH_RESET = 14'd500;
   localparam logic [GAIN_W-1:0]  GAIN_RESET   = 16'd256;
   localparam logic [RANGE_W-1:0] RANGE_RESET  = 14'd1000;

   typedef struct packed {
      logic [WIDTH_W-1:0] body_width;
      logic [WIDTH_W-1:0] body_length;
      logic [GAIN_W-1:0]  force_gain;
      logic [RANGE_W-1:0] reach_range;
   } lrf_cfg_type;

   typedef struct packed {
      logic point_present;
      logic last_point;
   } lrf_kind_type;

   function automatic logic [E_W-1:0] exp_int_q30(input logic [1:0] idx);
      logic [E_W-1:0] v;
      unique case (idx)
         2'd0:    v = ONE_Q30;
         2'd1:    v = 31'd395007542;
         default: v = 31'd145315154;
      endcase
      return v;
   endfunction

   function automatic logic [E_W-1:0] exp_frac_q30(input logic [3:0] k);
      logic [E_W-1:0] v;
      unique case (k)
         4'd0:    v = 31'd651257337;
         4'd1:    v = 31'd836230973;
         4'd2:    v = 31'd947573834;
         4'd3:    v = 31'd1008687096;
         4'd4:    v = 31'd1040706261;
         4'd5:    v = 31'd1057095000;
         4'd6:    v = 31'd1065385899;
         4'd7:    v = 31'd1069555701;
         4'd8:    v = 31'd1071646719;
         4'd9:    v = 31'd1072693760;
         4'd10:   v = 31'd1073217664;
         4'd11:   v = 31'd1073479712;
         4'd12:   v = 31'd1073610760;
         4'd13:   v = 31'd1073676290;
         4'd14:   v = 31'd1073709056;
         default: v = 31'd1073725440;
      endcase
      return v;
   endfunction

   function automatic logic [30:0] atan_q31(input logic [4:0] i);
      logic [30:0] v;
      unique case (i)
         5'd0:    v = 31'h20000000;
         5'd1:    v = 31'h12E4051E;
         5'd2:    v = 31'h09FB385B;
         5'd3:    v = 31'h051111D4;
         5'd4:    v = 31'h028B0D43;
         5'd5:    v = 31'h0145D7E1;
         5'd6:    v = 31'h00A2F61E;
         5'd7:    v = 31'h00517C55;
         5'd8:    v = 31'h0028BE53;
         5'd9:    v = 31'h00145F2F;
         5'd10:   v = 31'h000A2F98;
         5'd11:   v = 31'h000517CC;
         5'd12:   v = 31'h00028BE6;
         5'd13:   v = 31'h000145F3;
         5'd14:   v = 31'h0000A2FA;
         5'd15:   v = 31'h0000517D;
         5'd16:   v = 31'h000028BE;
         5'd17:   v = 31'h0000145F;
         5'd18:   v = 31'h00000A30;
         5'd19:   v = 31'h00000518;
         5'd20:   v = 31'h0000028C;
         5'd21:   v = 31'h00000146;
         5'd22:   v = 31'h000000A3;
         5'd23:   v = 31'h00000051;
         default: v = 31'h00000000;
      endcase
      return v;
   endfunction

endpackage

### rtl/core/lrf_front.sv
// Front end of the lidar repulsive force field block: takes requests, drops
// those that carry neither a point nor a scan end, and queues the rest.
// Depends on lrf_pkg.
module lrf_front #(
   parameter int COORD_WIDTH = lrf_pkg::COORD_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // point_x, point_y, zero fill
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // point_present
   input  logic                                   req_tuser,
   input  logic                                   req_tlast,
   output logic                                   q_valid,
   output logic signed [COORD_WIDTH-1:0]          q_point_x,
   output logic signed [COORD_WIDTH-1:0]          q_point_y,
   output lrf_pkg::lrf_kind_type                  q_kind,
   input  logic                                   q_pop
);
   import lrf_pkg::*;

   localparam int QP_W = $clog2(QUEUE_DEPTH);

   logic signed [COORD_WIDTH-1:0] px_mem [QUEUE_DEPTH];
   logic signed [COORD_WIDTH-1:0] py_mem [QUEUE_DEPTH];
   lrf_kind_type                  kind_mem [QUEUE_DEPTH];
   logic [QP_W-1:0]               wr_ptr_ff;
   logic [QP_W-1:0]               rd_ptr_ff;
   logic [QP_W:0]                 count_ff;
   logic                          accept;
   logic                          push;
   logic                          pop;

   assign req_tready = (count_ff != (QP_W+1)'(QUEUE_DEPTH));
   assign accept     = req_tvalid && req_tready;
   assign push       = accept && (req_tuser || req_tlast);
   assign q_valid    = (count_ff != '0);
   assign pop        = q_pop && q_valid;

   assign q_point_x = px_mem[rd_ptr_ff];
   assign q_point_y = py_mem[rd_ptr_ff];
   assign q_kind    = kind_mem[rd_ptr_ff];

   always_ff @(posedge clock) begin
      if (push) begin
         px_mem[wr_ptr_ff]   <= req_tdata[COORD_WIDTH-1:0];
         py_mem[wr_ptr_ff]   <= req_tdata[2*COORD_WIDTH-1:COORD_WIDTH];
         kind_mem[wr_ptr_ff] <= '{point_present: req_tuser, last_point: req_tlast};
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (push) begin
            wr_ptr_ff <= wr_ptr_ff + 1'b1;
         end
         if (pop) begin
            rd_ptr_ff <= rd_ptr_ff + 1'b1;
         end
         if (push && !pop) begin
            count_ff <= count_ff + 1'b1;
         end else if (pop && !push) begin
            count_ff <= count_ff - 1'b1;
         end
      end
   end

`ifndef SYNTH
   a_count_bound: assert property (@(posedge clock) disable iff (reset)
      count_ff <= (QP_W+1)'(QUEUE_DEPTH))
      else $error("request queue count beyond its depth");
`endif

endmodule

### rtl/core/lrf_sqrt.sv
// Digit-serial integer square root, one result bit per cycle.
// Shared by the distance and magnitude paths; depends on lrf_pkg.
module lrf_sqrt (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               start,
   input  logic [lrf_pkg::SQRT_RAD_W-1:0]     radicand,
   output logic                               busy,
   output logic [lrf_pkg::SQRT_ROOT_W-1:0]    root
);
   import lrf_pkg::*;

   localparam int REM_W = SQRT_ROOT_W + 3;
   localparam int CNT_W = $clog2(SQRT_ROOT_W + 1);

   logic [SQRT_RAD_W-1:0]  rad_ff;
   logic [REM_W-1:0]       rem_ff;
   logic [SQRT_ROOT_W-1:0] root_ff;
   logic [CNT_W-1:0]       cnt_ff;
   logic                   busy_ff;
   logic [REM_W-1:0]       rem_sh;
   logic [REM_W-1:0]       trial;
   logic                   fits;

   assign rem_sh = {rem_ff[REM_W-3:0], rad_ff[SQRT_RAD_W-1:SQRT_RAD_W-2]};
   assign trial  = REM_W'({root_ff, 2'b01});
   assign fits   = (rem_sh >= trial);
   assign busy   = busy_ff;
   assign root   = root_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         cnt_ff  <= '0;
      end else if (start) begin
         busy_ff <= 1'b1;
         cnt_ff  <= CNT_W'(SQRT_ROOT_W);
         rad_ff  <= radicand;
         rem_ff  <= '0;
         root_ff <= '0;
      end else if (busy_ff) begin
         rad_ff <= {rad_ff[SQRT_RAD_W-3:0], 2'b00};
         if (fits) begin
            rem_ff  <= rem_sh - trial;
            root_ff <= {root_ff[SQRT_ROOT_W-2:0], 1'b1};
         end else begin
            rem_ff  <= rem_sh;
            root_ff <= {root_ff[SQRT_ROOT_W-2:0], 1'b0};
         end
         cnt_ff <= cnt_ff - 1'b1;
         if (cnt_ff == CNT_W'(1)) begin
            busy_ff <= 1'b0;
         end
      end
   end

endmodule

### rtl/core/lrf_engine.sv
// Back end of the lidar repulsive force field block: per-corner Gaussian force
// evaluation, saturating sums, and the magnitude and CORDIC angle at scan end.
// Depends on lrf_pkg and lrf_sqrt.
module lrf_engine #(
   parameter int COORD_WIDTH = lrf_pkg::COORD_WIDTH_DEFAULT,
   parameter int ACC_WIDTH   = lrf_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   input  lrf_pkg::lrf_cfg_type                cfg,
   input  logic                                q_valid,
   input  logic signed [COORD_WIDTH-1:0]       q_point_x,
   input  logic signed [COORD_WIDTH-1:0]       q_point_y,
   input  lrf_pkg::lrf_kind_type               q_kind,
   output logic                                q_pop,
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // force_magnitude, force_angle
   output logic [lrf_pkg::RSP_TDATA_W-1:0]     rsp_tdata
);
   import lrf_pkg::*;

   localparam int M_W   = (COORD_WIDTH > WIDTH_W) ? COORD_WIDTH : WIDTH_W;
   localparam int DX_W  = M_W + 2;
   localparam int AX_W  = M_W + 1;
   localparam int D_W   = 2*AX_W + 1;
   localparam int S_W   = 2*RANGE_W + 3;
   localparam int N_W   = F_W + AX_W;
   localparam int DR_W  = SQRT_ROOT_W + 1;

   typedef enum logic [3:0] {
      ST_IDLE, ST_SQ, ST_RANGE, ST_DIV, ST_EXPI, ST_EXP, ST_FORCE, ST_WAITSQ,
      ST_CDIV, ST_ACC, ST_NEXT, ST_MAG, ST_MAG2, ST_NORM, ST_CORDIC, ST_WAITOUT
   } state_type;

   state_type                    state_ff;
   logic signed [COORD_WIDTH-1:0] px_ff, py_ff;
   logic                         last_ff;
   logic [CORNER_W-1:0]          corner_ff;
   logic [AX_W-1:0]              ax_ff, ay_ff;
   logic                         dxneg_ff, dxpos_ff, dyneg_ff, dypos_ff;
   logic [2*AX_W-1:0]            sqx_ff, sqy_ff;
   logic [S_W-1:0]               s_ff;
   logic [4:0]                   j_ff;
   logic [TQ_W-1:0]              tq_ff;
   logic [3:0]                   k_ff;
   logic [E_W-1:0]               e_ff;
   logic [F_W-1:0]               f_ff;
   logic [SQRT_ROOT_W-1:0]       dq_ff;
   logic [DR_W-1:0]              remx_ff, remy_ff;
   logic [Q_W-1:0]               nlx_ff, nly_ff, qx_ff, qy_ff;
   logic signed [ACC_WIDTH-1:0]  sumx_ff, sumy_ff;
   logic [ACC_WIDTH-1:0]         ux_ff, uy_ff;
   logic                         negx_ff, negy_ff, big_ff, msat_ff;
   logic [63:0]                  mx_ff, my_ff;
   logic signed [CORDIC_W-1:0]   cx_ff, cy_ff, cz_ff;
   logic [4:0]                   i_ff;
   logic [ANG_W-1:0]             ang_ff;
   logic                         rsp_valid_ff;
   logic [MAG_W-1:0]             rsp_mag_ff;
   logic [ANG_W-1:0]             rsp_ang_ff;

   logic                         cxpos, cypos;
   logic signed [DX_W-1:0]       px2, py2, wx, wy, cx2, cy2, dx, dy;
   logic [AX_W-1:0]              ax, ay;
   logic [D_W-1:0]               d;
   logic [2*RANGE_W-1:0]         r2;
   logic [S_W-1:0]               lim, den, den_op, s_op, s_sub;
   logic                         in_range, q_bit;
   logic [2*E_W-1:0]             e_prod;
   logic [E_W-1:0]               e_mul;
   logic [GAIN_W+E_W:0]          f_full;
   logic [N_W-1:0]               nx, ny;
   logic [DR_W-1:0]              rsx, rsy;
   logic                         bx, by;
   logic signed [ACC_WIDTH-1:0]  fx, fy;
   logic signed [ACC_WIDTH:0]    addx, addy;
   logic signed [ACC_WIDTH-1:0]  newx, newy;
   logic [ACC_WIDTH-1:0]         absx, absy, orv;
   logic [64:0]                  msum;
   logic signed [CORDIC_W-1:0]   sx, sy, at;
   logic [30:0]                  zc;
   logic [16:0]                  a17, ang17;
   logic                         sqrt_start, sqrt_busy;
   logic [SQRT_RAD_W-1:0]        sqrt_rad;
   logic [SQRT_ROOT_W-1:0]       sqrt_root;
   logic                         out_free;
   logic                         rsp_load;

   function automatic logic signed [ACC_WIDTH-1:0] sat_add(
      input logic signed [ACC_WIDTH:0] s
   );
      logic signed [ACC_WIDTH-1:0] r;
      if (s[ACC_WIDTH] != s[ACC_WIDTH-1]) begin
         r = s[ACC_WIDTH] ? {1'b1, {(ACC_WIDTH-1){1'b0}}} : {1'b0, {(ACC_WIDTH-1){1'b1}}};
      end else begin
         r = s[ACC_WIDTH-1:0];
      end
      return r;
   endfunction

   always_comb begin
      cxpos = (corner_ff == CORNER_W'(1)) || (corner_ff == CORNER_W'(2));
      cypos = corner_ff[CORNER_W-1];
      px2   = DX_W'($signed({px_ff, 1'b0}));
      py2   = DX_W'($signed({py_ff, 1'b0}));
      wx    = DX_W'($signed({1'b0, cfg.body_width}));
      wy    = DX_W'($signed({1'b0, cfg.body_length}));
      cx2   = cxpos ? wx : -wx;
      cy2   = cypos ? wy : -wy;
      dx    = px2 - cx2;
      dy    = py2 - cy2;
      ax    = dx[DX_W-1] ? AX_W'(-dx) : AX_W'(dx);
      ay    = dy[DX_W-1] ? AX_W'(-dy) : AX_W'(dy);

      d        = D_W'(sqx_ff) + D_W'(sqy_ff);
      r2       = cfg.reach_range * cfg.reach_range;
      lim      = S_W'({r2, 2'b00});
      den      = S_W'({r2, 1'b0});
      in_range = (d != '0) && (d <= D_W'(lim));

      den_op = (j_ff == 5'd17) ? {den[S_W-2:0], 1'b0} : den;
      s_op   = (j_ff < 5'd16) ? {s_ff[S_W-2:0], 1'b0} : s_ff;
      q_bit  = (s_op >= den_op);
      s_sub  = q_bit ? (s_op - den_op) : s_op;

      e_prod = e_ff * (tq_ff[{1'b0, ~k_ff}] ? exp_frac_q30(k_ff) : ONE_Q30);
      e_mul  = E_W'((e_prod + (2*E_W)'(ONE_Q30 >> 1)) >> 30);
      f_full = cfg.force_gain * e_ff + (GAIN_W+E_W+1)'(1 << 21);

      nx = f_ff * ax_ff;
      ny = f_ff * ay_ff;
      rsx = {remx_ff[DR_W-2:0], nlx_ff[Q_W-1]};
      rsy = {remy_ff[DR_W-2:0], nly_ff[Q_W-1]};
      bx  = (rsx >= DR_W'(dq_ff));
      by  = (rsy >= DR_W'(dq_ff));

      fx = ACC_WIDTH'($signed({1'b0, qx_ff}));
      fy = ACC_WIDTH'($signed({1'b0, qy_ff}));
      if (dxpos_ff) fx = -fx;
      if (dypos_ff) fy = -fy;
      if ((cfg.body_width != '0) && (cxpos ? dxneg_ff : dxpos_ff)) fx = '0;
      if ((cfg.body_length != '0) && (cypos ? dyneg_ff : dypos_ff)) fy = '0;
      addx = (ACC_WIDTH+1)'(sumx_ff) + (ACC_WIDTH+1)'(fx);
      addy = (ACC_WIDTH+1)'(sumy_ff) + (ACC_WIDTH+1)'(fy);
      newx = sat_add(addx);
      newy = sat_add(addy);

      absx = sumx_ff[ACC_WIDTH-1] ? ACC_WIDTH'(-sumx_ff) : ACC_WIDTH'(sumx_ff);
      absy = sumy_ff[ACC_WIDTH-1] ? ACC_WIDTH'(-sumy_ff) : ACC_WIDTH'(sumy_ff);
      msum = {1'b0, mx_ff} + {1'b0, my_ff};
      orv  = ux_ff | uy_ff;

      sx = cx_ff >>> i_ff;
      sy = cy_ff >>> i_ff;
      at = CORDIC_W'($signed({2'b00, atan_q31(i_ff)}));

      if (cz_ff < 0) begin
         zc = '0;
      end else if (cz_ff > CORDIC_W'(32'h40000000)) begin
         zc = 31'h40000000;
      end else begin
         zc = cz_ff[30:0];
      end
      a17 = 17'((zc + 31'd32768) >> 16);
      priority if (!negx_ff && !negy_ff) begin
         ang17 = a17;
      end else if (negx_ff && !negy_ff) begin
         ang17 = 17'd32768 - a17;
      end else if (negx_ff && negy_ff) begin
         ang17 = a17 - 17'd32768;
      end else begin
         ang17 = -a17;
      end
   end

   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign rsp_load   = (state_ff == ST_WAITOUT) && (i_ff != 5'(CORDIC_STEPS)) &&
                       !sqrt_busy && out_free;
   assign q_pop      = (state_ff == ST_IDLE) && q_valid;
   assign sqrt_start = ((state_ff == ST_RANGE) && in_range) ||
                       ((state_ff == ST_MAG2) && !(big_ff || msum[64]));
   assign sqrt_rad   = (state_ff == ST_RANGE) ? (SQRT_RAD_W'(d) << 16) : msum[63:0];
   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {rsp_ang_ff, rsp_mag_ff};

   lrf_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .busy     (sqrt_busy),
      .root     (sqrt_root)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         sumx_ff      <= '0;
         sumy_ff      <= '0;
         rsp_valid_ff <= 1'b0;
         corner_ff    <= '0;
      end else begin
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (q_valid) begin
                  px_ff     <= q_point_x;
                  py_ff     <= q_point_y;
                  last_ff   <= q_kind.last_point;
                  corner_ff <= '0;
                  if (q_kind.point_present) begin
                     state_ff <= ST_SQ;
                  end else if (q_kind.last_point) begin
                     state_ff <= ST_MAG;
                  end
               end
            end
            ST_SQ: begin
               ax_ff    <= ax;
               ay_ff    <= ay;
               dxneg_ff <= dx < 0;
               dxpos_ff <= dx > 0;
               dyneg_ff <= dy < 0;
               dypos_ff <= dy > 0;
               sqx_ff   <= ax * ax;
               sqy_ff   <= ay * ay;
               state_ff <= ST_RANGE;
            end
            ST_RANGE: begin
               s_ff  <= S_W'(d);
               j_ff  <= 5'd17;
               tq_ff <= '0;
               state_ff <= in_range ? ST_DIV : ST_NEXT;
            end
            ST_DIV: begin
               s_ff  <= s_sub;
               tq_ff <= {tq_ff[TQ_W-2:0], q_bit};
               j_ff  <= j_ff - 1'b1;
               if (j_ff == 5'd0) begin
                  state_ff <= ST_EXPI;
               end
            end
            ST_EXPI: begin
               e_ff     <= exp_int_q30(tq_ff[TQ_W-1:TQ_W-2]);
               k_ff     <= '0;
               state_ff <= ST_EXP;
            end
            ST_EXP: begin
               e_ff <= e_mul;
               k_ff <= k_ff + 1'b1;
               if (k_ff == 4'(EXP_STEPS-1)) begin
                  state_ff <= ST_FORCE;
               end
            end
            ST_FORCE: begin
               f_ff     <= F_W'(f_full >> 22);
               state_ff <= ST_WAITSQ;
            end
            ST_WAITSQ: begin
               if (!sqrt_busy) begin
                  dq_ff   <= sqrt_root;
                  remx_ff <= DR_W'(nx >> Q_W);
                  remy_ff <= DR_W'(ny >> Q_W);
                  nlx_ff  <= nx[Q_W-1:0];
                  nly_ff  <= ny[Q_W-1:0];
                  qx_ff   <= '0;
                  qy_ff   <= '0;
                  j_ff    <= 5'(Q_W-1);
                  state_ff <= (sqrt_root == '0) ? ST_NEXT : ST_CDIV;
               end
            end
            ST_CDIV: begin
               remx_ff <= bx ? (rsx - DR_W'(dq_ff)) : rsx;
               remy_ff <= by ? (rsy - DR_W'(dq_ff)) : rsy;
               nlx_ff  <= {nlx_ff[Q_W-2:0], 1'b0};
               nly_ff  <= {nly_ff[Q_W-2:0], 1'b0};
               qx_ff   <= {qx_ff[Q_W-2:0], bx};
               qy_ff   <= {qy_ff[Q_W-2:0], by};
               j_ff    <= j_ff - 1'b1;
               if (j_ff == 5'd0) begin
                  state_ff <= ST_ACC;
               end
            end
            ST_ACC: begin
               sumx_ff  <= newx;
               sumy_ff  <= newy;
               state_ff <= ST_NEXT;
            end
            ST_NEXT: begin
               if (corner_ff == CORNER_W'(CORNER_COUNT-1)) begin
                  state_ff <= last_ff ? ST_MAG : ST_IDLE;
               end else begin
                  corner_ff <= corner_ff + 1'b1;
                  state_ff  <= ST_SQ;
               end
            end
            ST_MAG: begin
               ux_ff    <= absx;
               uy_ff    <= absy;
               negx_ff  <= sumx_ff < 0;
               negy_ff  <= sumy_ff < 0;
               big_ff   <= (absx > ACC_WIDTH'(32'hFFFFFFFF)) ||
                           (absy > ACC_WIDTH'(32'hFFFFFFFF));
               mx_ff    <= absx[31:0] * absx[31:0];
               my_ff    <= absy[31:0] * absy[31:0];
               state_ff <= ST_MAG2;
            end
            ST_MAG2: begin
               msat_ff <= big_ff || msum[64];
               ang_ff  <= '0;
               i_ff    <= '0;
               state_ff <= (orv == '0) ? ST_WAITOUT : ST_NORM;
            end
            ST_NORM: begin
               if (orv >= (ACC_WIDTH'(1) << 30)) begin
                  ux_ff <= ux_ff >> 1;
                  uy_ff <= uy_ff >> 1;
               end else if (orv < (ACC_WIDTH'(1) << 29)) begin
                  ux_ff <= ux_ff << 1;
                  uy_ff <= uy_ff << 1;
               end else begin
                  cx_ff    <= CORDIC_W'(ux_ff[30:0]);
                  cy_ff    <= CORDIC_W'(uy_ff[30:0]);
                  cz_ff    <= '0;
                  i_ff     <= '0;
                  state_ff <= ST_CORDIC;
               end
            end
            ST_CORDIC: begin
               if (cy_ff > 0) begin
                  cx_ff <= cx_ff + sy;
                  cy_ff <= cy_ff - sx;
                  cz_ff <= cz_ff + at;
               end else begin
                  cx_ff <= cx_ff - sy;
                  cy_ff <= cy_ff + sx;
                  cz_ff <= cz_ff - at;
               end
               i_ff <= i_ff + 1'b1;
               if (i_ff == 5'(CORDIC_STEPS-1)) begin
                  state_ff <= ST_WAITOUT;
               end
            end
            ST_WAITOUT: begin
               if (i_ff == 5'(CORDIC_STEPS)) begin
                  ang_ff <= ang17[ANG_W-1:0];
                  i_ff   <= '0;
               end else if (rsp_load) begin
                  rsp_mag_ff   <= msat_ff ? {MAG_W{1'b1}} : sqrt_root;
                  rsp_ang_ff   <= ang_ff;
                  sumx_ff      <= '0;
                  sumy_ff      <= '0;
                  state_ff     <= ST_IDLE;
               end
            end
            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

`ifndef SYNTH
   a_sqrt_free: assert property (@(posedge clock) disable iff (reset)
      sqrt_start |-> !sqrt_busy)
      else $error("square root started while still busy");
   a_exp_index: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_EXPI) |-> (tq_ff[TQ_W-1:TQ_W-2] != 2'b11))
      else $error("exponent argument beyond two");
   a_div_nonzero: assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_CDIV) |-> (dq_ff != '0))
      else $error("component division by zero distance");
`endif

endmodule

### rtl/core/lidar_repulsive_force_field.sv
// Lidar repulsive force field: top level with the configuration registers,
// the request queue front end and the force evaluation back end.
// Depends on lrf_pkg, lrf_front, lrf_engine and lrf_sqrt.
//
// Each request carries one lidar point and sums a Gaussian repulsion from the
// four robot corners; a request marked last emits the force magnitude (Q24.8)
// and angle and clears the sums. In the back end, a corner out of range is
// skipped; one in range passes the bit-serial quotient divider, the 16-step
// exponent multiplier and the bit-serial component dividers. The scan-end
// result passes operand normalisation and the 24-step CORDIC, with the
// 32-step square root running alongside. A four-deep queue takes requests
// while the back end works, and a result register holds the response while
// further requests are accepted.
module lidar_repulsive_force_field #(
   parameter int COORD_WIDTH = lrf_pkg::COORD_WIDTH_DEFAULT,
   parameter int ACC_WIDTH   = lrf_pkg::ACC_WIDTH_DEFAULT
) (
   input  logic                                   clock,
   input  logic                                   reset,
   input  logic                                   req_tvalid,
   output logic                                   req_tready,
   // point_x, point_y, zero fill
   input  logic [((2*COORD_WIDTH+7)/8)*8-1:0]     req_tdata,
   // point_present
   input  logic                                   req_tuser,
   input  logic                                   req_tlast,
   output logic                                   rsp_tvalid,
   input  logic                                   rsp_tready,
   // force_magnitude, force_angle
   output logic [lrf_pkg::RSP_TDATA_W-1:0]        rsp_tdata,
   input  logic                                   csr_we,
   input  logic [lrf_pkg::CSR_ADDR_W-1:0]         csr_addr,
   input  logic [lrf_pkg::CSR_DATA_W-1:0]         csr_wdata
);
   import lrf_pkg::*;

   lrf_cfg_type                   cfg_ff;
   logic                          q_valid;
   logic signed [COORD_WIDTH-1:0] q_point_x;
   logic signed [COORD_WIDTH-1:0] q_point_y;
   lrf_kind_type                  q_kind;
   logic                          q_pop;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.body_width  <= WIDTH_RESET;
         cfg_ff.body_length <= LENGTH_RESET;
         cfg_ff.force_gain  <= GAIN_RESET;
         cfg_ff.reach_range <= RANGE_RESET;
      end else if (csr_we) begin
         unique case (csr_index_type'(csr_addr))
            CSR_WIDTH:  cfg_ff.body_width  <= csr_wdata[WIDTH_W-1:0];
            CSR_LENGTH: cfg_ff.body_length <= csr_wdata[WIDTH_W-1:0];
            CSR_GAIN:   cfg_ff.force_gain  <= csr_wdata[GAIN_W-1:0];
            CSR_RANGE:  cfg_ff.reach_range <= csr_wdata[RANGE_W-1:0];
            default: begin
            end
         endcase
      end
   end

   lrf_front #(
      .COORD_WIDTH (COORD_WIDTH)
   ) u_front (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .req_tlast  (req_tlast),
      .q_valid    (q_valid),
      .q_point_x  (q_point_x),
      .q_point_y  (q_point_y),
      .q_kind     (q_kind),
      .q_pop      (q_pop)
   );

   lrf_engine #(
      .COORD_WIDTH (COORD_WIDTH),
      .ACC_WIDTH   (ACC_WIDTH)
   ) u_engine (
      .clock      (clock),
      .reset      (reset),
      .cfg        (cfg_ff),
      .q_valid    (q_valid),
      .q_point_x  (q_point_x),
      .q_point_y  (q_point_y),
      .q_kind     (q_kind),
      .q_pop      (q_pop),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

endmodule
